/* rtl/kmq_pkg.sv */
// Shared constants, codes and control structs for the keyed mailbox queue manager.
// Used by every file in rtl/; has no dependencies of its own.
package kmq_pkg;

   // Default sizing, used as the top level's parameter defaults
   localparam int NUM_BOXES_DEF   = 8;
   localparam int QUEUE_DEPTH_DEF = 16;

   // Field widths
   localparam int OP_W       = 2;
   localparam int KEY_W      = 32;
   localparam int BOXID_W    = 8;
   localparam int MSG_W      = 32;
   localparam int STATUS_W   = 2;
   localparam int RBOX_W     = 3;
   localparam int BKEY_W     = 31;
   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 40;

   // Operation codes
   localparam logic [OP_W-1:0] OP_CREATE = 2'd0;
   localparam logic [OP_W-1:0] OP_SEND   = 2'd1;
   localparam logic [OP_W-1:0] OP_RECV   = 2'd2;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_ERR   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

   // Box table write controls
   typedef struct packed {
      logic wr_en;
      logic set_used;
   } tbl_wr_type;

   // Message store port controls
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } msg_ctl_type;

endpackage

/* rtl/keyed_mailbox_queue_manager_unit.sv */
// Keyed mailbox queue manager, top level with the request sequencer.
// Create scans boxes (NUM_BOXES at most, fewer when the key sits in a lower box); send and
// receive go through S_ACCESS, a receive that pops also through S_POP; a bad key, bad box id
// or unused opcode goes straight to S_DONE, which waits for the output register. req_tready
// is high only while idle, so no new item is taken before the last one leaves S_DONE.
// Reset (synchronous, active high) frees all boxes; no clearing pass is needed.
module keyed_mailbox_queue_manager_unit #(
   parameter int NUM_BOXES   = kmq_pkg::NUM_BOXES_DEF,
   parameter int QUEUE_DEPTH = kmq_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // [1:0] operation, [33:2] key, [41:34] box_id, [73:42] message, [79:74] zero
   input  logic [kmq_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [1:0] status, [4:2] result_box, [36:5] message_out, [39:37] zero
   output logic [kmq_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   localparam int BOX_W     = (NUM_BOXES > 1) ? $clog2(NUM_BOXES) : 1;
   localparam int PTR_W     = $clog2(QUEUE_DEPTH);
   localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
   localparam int MSG_DEPTH = NUM_BOXES * QUEUE_DEPTH;
   localparam int MSG_AW    = $clog2(MSG_DEPTH);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_SCAN   = 5'b00010,
      S_ACCESS = 5'b00100,
      S_POP    = 5'b01000,
      S_DONE   = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [kmq_pkg::OP_W-1:0]     op_ff, op_in;
   logic [kmq_pkg::BKEY_W-1:0]   key_ff, key_in;
   logic [BOX_W-1:0]             box_ff, box_in;
   logic [kmq_pkg::MSG_W-1:0]    msg_ff, msg_in;
   logic [BOX_W-1:0]             scan_idx_ff, scan_idx_in;
   logic                         free_found_ff, free_found_in;
   logic [BOX_W-1:0]             free_idx_ff, free_idx_in;
   logic [kmq_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [kmq_pkg::RBOX_W-1:0]   rbox_ff, rbox_in;
   logic [kmq_pkg::MSG_W-1:0]    mout_ff, mout_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [kmq_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // Request fields
   logic [kmq_pkg::OP_W-1:0]    req_op;
   logic [kmq_pkg::KEY_W-1:0]   req_key;
   logic [kmq_pkg::BOXID_W-1:0] req_box_id;
   logic [kmq_pkg::MSG_W-1:0]   req_message;

   // Box table
   logic [BOX_W-1:0]           tbl_rd_addr;
   logic                       tbl_rd_used;
   logic [kmq_pkg::BKEY_W-1:0] tbl_rd_key;
   logic [PTR_W-1:0]           tbl_rd_rp;
   logic [PTR_W-1:0]           tbl_rd_wp;
   logic [CNT_W-1:0]           tbl_rd_cnt;
   kmq_pkg::tbl_wr_type        tbl_wr;
   logic [BOX_W-1:0]           tbl_wr_addr;
   logic [kmq_pkg::BKEY_W-1:0] tbl_wr_key;
   logic [PTR_W-1:0]           tbl_wr_rp;
   logic [PTR_W-1:0]           tbl_wr_wp;
   logic [CNT_W-1:0]           tbl_wr_cnt;

   // Message store
   kmq_pkg::msg_ctl_type      msg_ctl;
   logic [MSG_AW-1:0]         msg_addr;
   logic [MSG_AW-1:0]         msg_base;
   logic [kmq_pkg::MSG_W-1:0] msg_rd_data;

   logic req_fire;
   logic can_load;
   logic box_in_range;
   logic key_match;
   logic scan_last;
   logic q_full;
   logic q_empty;
   logic [PTR_W-1:0] wp_next;
   logic [PTR_W-1:0] rp_next;

   assign req_op      = req_tdata[1:0];
   assign req_key     = req_tdata[33:2];
   assign req_box_id  = req_tdata[41:34];
   assign req_message = req_tdata[73:42];

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign can_load   = !rsp_valid_ff || rsp_tready;

   assign box_in_range = !req_box_id[kmq_pkg::BOXID_W-1] &&
                         ({1'b0, req_box_id[kmq_pkg::BOXID_W-2:0]} <
                          kmq_pkg::BOXID_W'(NUM_BOXES));

   assign key_match = tbl_rd_used && (tbl_rd_key == key_ff);
   assign scan_last = (scan_idx_ff == BOX_W'(NUM_BOXES - 1));
   assign q_full    = (tbl_rd_cnt == CNT_W'(QUEUE_DEPTH));
   assign q_empty   = (tbl_rd_cnt == '0);
   assign wp_next   = (tbl_rd_wp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tbl_rd_wp + 1'b1;
   assign rp_next   = (tbl_rd_rp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tbl_rd_rp + 1'b1;
   assign msg_base  = MSG_AW'(box_ff) * MSG_AW'(QUEUE_DEPTH);

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      box_in        = box_ff;
      msg_in        = msg_ff;
      scan_idx_in   = scan_idx_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      status_in     = status_ff;
      rbox_in       = rbox_ff;
      mout_in       = mout_ff;

      tbl_rd_addr = '0;
      tbl_wr      = '0;
      tbl_wr_addr = box_ff;
      tbl_wr_key  = tbl_rd_key;
      tbl_wr_rp   = tbl_rd_rp;
      tbl_wr_wp   = tbl_rd_wp;
      tbl_wr_cnt  = tbl_rd_cnt;
      msg_ctl     = '0;
      msg_addr    = msg_base + MSG_AW'(tbl_rd_wp);

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in         = req_op;
               key_in        = req_key[kmq_pkg::BKEY_W-1:0];
               box_in        = req_box_id[BOX_W-1:0];
               msg_in        = req_message;
               scan_idx_in   = '0;
               free_found_in = 1'b0;
               free_idx_in   = '0;
               status_in     = kmq_pkg::ST_ERR;
               rbox_in       = '0;
               mout_in       = '0;
               state_in      = S_DONE;
               case (req_op)
                  kmq_pkg::OP_CREATE: begin
                     if (!req_key[kmq_pkg::KEY_W-1]) begin
                        state_in = S_SCAN;
                     end
                  end
                  kmq_pkg::OP_SEND, kmq_pkg::OP_RECV: begin
                     if (box_in_range) begin
                        tbl_rd_addr = req_box_id[BOX_W-1:0];
                        state_in    = S_ACCESS;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end

         S_SCAN: begin
            // Data in hand is for scan_idx_ff; fetch the next box meanwhile.
            if (!scan_last) begin
               tbl_rd_addr = scan_idx_ff + 1'b1;
            end
            if (!free_found_ff && !tbl_rd_used) begin
               free_found_in = 1'b1;
               free_idx_in   = scan_idx_ff;
            end
            tbl_wr_key = key_ff;
            tbl_wr_rp  = '0;
            tbl_wr_wp  = '0;
            tbl_wr_cnt = '0;
            if (key_match) begin
               tbl_wr.wr_en    = 1'b1;
               tbl_wr.set_used = 1'b1;
               tbl_wr_addr     = scan_idx_ff;
               status_in       = kmq_pkg::ST_OK;
               rbox_in         = kmq_pkg::RBOX_W'(scan_idx_ff);
               state_in        = S_DONE;
            end else if (scan_last) begin
               state_in = S_DONE;
               if (free_found_ff || !tbl_rd_used) begin
                  tbl_wr.wr_en    = 1'b1;
                  tbl_wr.set_used = 1'b1;
                  tbl_wr_addr     = free_found_ff ? free_idx_ff : scan_idx_ff;
                  status_in       = kmq_pkg::ST_OK;
                  rbox_in         = kmq_pkg::RBOX_W'(tbl_wr_addr);
               end
            end else begin
               scan_idx_in = scan_idx_ff + 1'b1;
            end
         end

         S_ACCESS: begin
            state_in = S_DONE;
            if (!tbl_rd_used) begin
               status_in = kmq_pkg::ST_ERR;
            end else if (op_ff == kmq_pkg::OP_SEND) begin
               if (q_full) begin
                  status_in = kmq_pkg::ST_FULL;
               end else begin
                  msg_ctl.wr_en = 1'b1;
                  msg_addr      = msg_base + MSG_AW'(tbl_rd_wp);
                  tbl_wr.wr_en  = 1'b1;
                  tbl_wr_wp     = wp_next;
                  tbl_wr_cnt    = tbl_rd_cnt + 1'b1;
                  status_in     = kmq_pkg::ST_OK;
               end
            end else begin
               if (q_empty) begin
                  status_in = kmq_pkg::ST_EMPTY;
               end else begin
                  msg_ctl.rd_en = 1'b1;
                  msg_addr      = msg_base + MSG_AW'(tbl_rd_rp);
                  tbl_wr.wr_en  = 1'b1;
                  tbl_wr_rp     = rp_next;
                  tbl_wr_cnt    = tbl_rd_cnt - 1'b1;
                  status_in     = kmq_pkg::ST_OK;
                  state_in      = S_POP;
               end
            end
         end

         S_POP: begin
            mout_in  = msg_rd_data;
            state_in = S_DONE;
         end

         S_DONE: begin
            if (can_load) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output register: loads the finished item, holds it until taken.
   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      if (state_ff == S_DONE && can_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {3'b000, mout_ff, rbox_ff, status_ff};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      box_ff        <= box_in;
      msg_ff        <= msg_in;
      scan_idx_ff   <= scan_idx_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      status_ff     <= status_in;
      rbox_ff       <= rbox_in;
      mout_ff       <= mout_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   kmq_box_table #(
      .NUM_BOXES   (NUM_BOXES),
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_box_table (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (tbl_rd_addr),
      .rd_used (tbl_rd_used),
      .rd_key  (tbl_rd_key),
      .rd_rp   (tbl_rd_rp),
      .rd_wp   (tbl_rd_wp),
      .rd_cnt  (tbl_rd_cnt),
      .wr_ctl  (tbl_wr),
      .wr_addr (tbl_wr_addr),
      .wr_key  (tbl_wr_key),
      .wr_rp   (tbl_wr_rp),
      .wr_wp   (tbl_wr_wp),
      .wr_cnt  (tbl_wr_cnt)
   );

   kmq_msg_store #(
      .NUM_BOXES   (NUM_BOXES),
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_msg_store (
      .clock   (clock),
      .ctl     (msg_ctl),
      .addr    (msg_addr),
      .wr_data (msg_ff),
      .rd_data (msg_rd_data)
   );

endmodule

/* rtl/kmq_box_table.sv */
// Mailbox table: per-box used bits plus a record memory holding key and queue pointers.
// One read port (registered) and one write port. Depends on kmq_pkg.
module kmq_box_table #(
   parameter int  NUM_BOXES   = kmq_pkg::NUM_BOXES_DEF,
   parameter int  QUEUE_DEPTH = kmq_pkg::QUEUE_DEPTH_DEF,
   localparam int BOX_W       = (NUM_BOXES > 1) ? $clog2(NUM_BOXES) : 1,
   localparam int PTR_W       = $clog2(QUEUE_DEPTH),
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [BOX_W-1:0]          rd_addr,
   output logic                      rd_used,
   output logic [kmq_pkg::BKEY_W-1:0] rd_key,
   output logic [PTR_W-1:0]          rd_rp,
   output logic [PTR_W-1:0]          rd_wp,
   output logic [CNT_W-1:0]          rd_cnt,
   input  kmq_pkg::tbl_wr_type       wr_ctl,
   input  logic [BOX_W-1:0]          wr_addr,
   input  logic [kmq_pkg::BKEY_W-1:0] wr_key,
   input  logic [PTR_W-1:0]          wr_rp,
   input  logic [PTR_W-1:0]          wr_wp,
   input  logic [CNT_W-1:0]          wr_cnt
);

   localparam int REC_W = kmq_pkg::BKEY_W + 2 * PTR_W + CNT_W;

   logic [NUM_BOXES-1:0] used_ff;
   logic [REC_W-1:0]     rec_mem [NUM_BOXES];
   logic [REC_W-1:0]     rd_rec_ff;
   logic                 rd_used_ff;

   // Used bits are the only state that reset clears; records are rewritten on create.
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else if (wr_ctl.wr_en && wr_ctl.set_used) begin
         used_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_ctl.wr_en) begin
         rec_mem[wr_addr] <= {wr_key, wr_rp, wr_wp, wr_cnt};
      end
      rd_rec_ff  <= rec_mem[rd_addr];
      rd_used_ff <= used_ff[rd_addr];
   end

   assign rd_used = rd_used_ff;
   assign {rd_key, rd_rp, rd_wp, rd_cnt} = rd_rec_ff;

endmodule

/* rtl/kmq_msg_store.sv */
// Message store: one circular queue region per box in a single-port RAM, registered read.
// Depends on kmq_pkg.
module kmq_msg_store #(
   parameter int  NUM_BOXES   = kmq_pkg::NUM_BOXES_DEF,
   parameter int  QUEUE_DEPTH = kmq_pkg::QUEUE_DEPTH_DEF,
   localparam int MSG_DEPTH   = NUM_BOXES * QUEUE_DEPTH,
   localparam int MSG_AW      = $clog2(MSG_DEPTH)
) (
   input  logic                     clock,
   input  kmq_pkg::msg_ctl_type     ctl,
   input  logic [MSG_AW-1:0]        addr,
   input  logic [kmq_pkg::MSG_W-1:0] wr_data,
   output logic [kmq_pkg::MSG_W-1:0] rd_data
);

   logic [kmq_pkg::MSG_W-1:0] mem [MSG_DEPTH];
   logic [kmq_pkg::MSG_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for keyed_mailbox_queue_manager_unit: directed and random
// request streams checked against an in-bench mailbox table predictor.
// Depends on rtl/kmq_pkg.sv and rtl/keyed_mailbox_queue_manager_unit.sv.
module tb;
   import kmq_pkg::*;

   localparam int NBOX         = NUM_BOXES_DEF;
   localparam int QDEPTH       = QUEUE_DEPTH_DEF;
   localparam int KEY_POOL_N   = 10;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 2 * NBOX + 16;
   localparam int PHASE_ITEMS  = 280;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [RBOX_W-1:0]   result_box;
      logic [MSG_W-1:0]    message_out;
   } mbox_rsp_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tready = 1'b0;
   logic                  req_tready;
   logic                  rsp_tvalid;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // mailbox table as the block should hold it
   logic               box_used [NBOX];
   logic [BKEY_W-1:0]  box_key  [NBOX];
   logic [MSG_W-1:0]   box_msgs [NBOX][QDEPTH];
   int unsigned        rd_ptr   [NBOX];
   int unsigned        wr_ptr   [NBOX];
   int unsigned        fill     [NBOX];

   mbox_rsp_type       pending_rsp[$];
   mbox_rsp_type       rsp_want;
   logic [KEY_W-1:0]   key_pool[KEY_POOL_N];
   int                 fail_count = 0;
   int                 items_sent = 0;
   int                 idle_pct   = 0;
   int                 stall_pct  = 0;
   int                 hold_seq   = 0;
   int                 hold_seen  = 0;
   int                 hold_left  = 0;

   keyed_mailbox_queue_manager_unit #(
      .NUM_BOXES   (NBOX),
      .QUEUE_DEPTH (QDEPTH)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic mbox_rsp_type mailbox_predict(logic [OP_W-1:0] op,
                                                    logic [KEY_W-1:0] key,
                                                    logic [BOXID_W-1:0] box_id,
                                                    logic [MSG_W-1:0] msg);
      mbox_rsp_type r;
      int           slot;
      int           b;
      r.status      = ST_ERR;
      r.result_box  = '0;
      r.message_out = '0;
      slot          = -1;
      case (op)
         OP_CREATE: begin
            if (!key[KEY_W-1]) begin
               // existing key wins over a free box
               for (int i = 0; i < NBOX; i++)
                  if (slot < 0 && box_used[i] && box_key[i] == key[BKEY_W-1:0]) slot = i;
               for (int i = 0; i < NBOX; i++)
                  if (slot < 0 && !box_used[i]) begin
                     slot        = i;
                     box_used[i] = 1'b1;
                     box_key[i]  = key[BKEY_W-1:0];
                  end
               if (slot >= 0) begin
                  rd_ptr[slot]  = 0;
                  wr_ptr[slot]  = 0;
                  fill[slot]    = 0;
                  r.status      = ST_OK;
                  r.result_box  = RBOX_W'(slot);
               end
            end
         end
         OP_SEND, OP_RECV: begin
            if (!box_id[BOXID_W-1] && box_id < NBOX && box_used[box_id]) begin
               b = int'(box_id);
               if (op == OP_SEND) begin
                  if (fill[b] >= QDEPTH) begin
                     r.status = ST_FULL;
                  end else begin
                     box_msgs[b][wr_ptr[b]] = msg;
                     wr_ptr[b] = (wr_ptr[b] + 1) % QDEPTH;
                     fill[b]++;
                     r.status = ST_OK;
                  end
               end else begin
                  if (fill[b] == 0) begin
                     r.status = ST_EMPTY;
                  end else begin
                     r.message_out = box_msgs[b][rd_ptr[b]];
                     rd_ptr[b] = (rd_ptr[b] + 1) % QDEPTH;
                     fill[b]--;
                     r.status = ST_OK;
                  end
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("%0t: mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
      fail_count++;
   endtask

   // valid stays high across back-to-back items; only lowered for an idle gap
   task automatic send_item(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                            logic [BOXID_W-1:0] box_id, logic [MSG_W-1:0] msg);
      int gap;
      gap = 0;
      while ($urandom_range(0, 99) < idle_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'({msg, box_id, key, op});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_rsp.push_back(mailbox_predict(op, key, box_id, msg));
      items_sent++;
   endtask

   task automatic set_idling(int sender_pct, int receiver_pct);
      idle_pct = sender_pct;
      stall_pct <= receiver_pct;
   endtask

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_rsp.size() == 0) begin
            flag_mismatch("unexpected item", 64'(rsp_tdata), 64'd0);
         end else begin
            rsp_want = pending_rsp.pop_front();
            if (rsp_tdata[1:0] !== rsp_want.status)
               flag_mismatch("status", 64'(rsp_tdata[1:0]), 64'(rsp_want.status));
            if (rsp_tdata[4:2] !== rsp_want.result_box)
               flag_mismatch("result_box", 64'(rsp_tdata[4:2]), 64'(rsp_want.result_box));
            if (rsp_tdata[36:5] !== rsp_want.message_out)
               flag_mismatch("message_out", 64'(rsp_tdata[36:5]), 64'(rsp_want.message_out));
         end
      end
   end

   // receiver stall generator; a long hold is counted down here in cycles
   always @(posedge clock) begin
      if (hold_seq != hold_seen) begin
         hold_seen = hold_seq;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   task automatic test_basic_ops;
      send_item(OP_RECV, '0, 8'd0, '0);                   // box still free
      send_item(OP_SEND, '0, 8'd0, $urandom);
      send_item(OP_CREATE, key_pool[0], 8'd0, '0);        // claims box 0
      send_item(OP_CREATE, key_pool[1], 8'd0, '0);        // claims box 1
      send_item(OP_CREATE, 32'hFFFF_FFFF, 8'd0, '0);      // negative key
      send_item(OP_CREATE, 32'h8000_0000, 8'd0, '0);
      send_item(OP_RECV, $urandom, 8'd0, $urandom);       // empty queue
      send_item(OP_SEND, $urandom, 8'd0, 32'h0000_0000);
      send_item(OP_SEND, $urandom, 8'd0, 32'hFFFF_FFFF);
      send_item(OP_SEND, '0, 8'd1, 32'h8000_0000);
      send_item(OP_RECV, '0, 8'd0, '0);
      send_item(OP_RECV, '0, 8'd0, '0);
      send_item(OP_RECV, '0, 8'd1, '0);
      send_item(OP_SEND, '0, 8'd0, 32'h7FFF_FFFF);
      send_item(OP_CREATE, key_pool[0], 8'd5, '0);        // same key again: clears box 0
      send_item(OP_RECV, '0, 8'd0, '0);
      send_item(OP_SEND, '0, 8'hFF, $urandom);            // bad box ids
      send_item(OP_RECV, '0, 8'(NBOX), '0);
      send_item(OP_SEND, '0, 8'h7F, $urandom);
      send_item(OP_RECV, '0, 8'h80, '0);
      send_item(OP_SEND, '0, 8'd2, $urandom);             // box never created
      send_item(OP_UNUSED, $urandom, BOXID_W'($urandom), $urandom);
      send_item(OP_UNUSED, '0, 8'd0, '0);
   endtask

   // box 1 read pointer is off zero here, so the fill also wraps
   task automatic test_queue_full;
      repeat (QDEPTH + 1) send_item(OP_SEND, $urandom, 8'd1, $urandom);
      repeat (QDEPTH + 1) send_item(OP_RECV, $urandom, 8'd1, $urandom);
   endtask

   task automatic test_table_full;
      for (int i = 2; i < NBOX; i++)
         send_item(OP_CREATE, key_pool[i], BOXID_W'($urandom), $urandom);
      send_item(OP_CREATE, key_pool[NBOX], '0, '0);
      send_item(OP_CREATE, key_pool[1], '0, '0);
      send_item(OP_CREATE, $urandom & 32'h7FFF_FFFF, '0, '0);
   endtask

   task automatic random_traffic(int count);
      int start;
      int r;
      int b;
      int n;
      start = items_sent;
      while (items_sent - start < count) begin
         r = $urandom_range(0, 99);
         b = $urandom_range(0, NBOX - 1);
         if (r < 15) begin
            if ($urandom_range(0, 4) == 0)
               send_item(OP_CREATE, $urandom, BOXID_W'($urandom), $urandom);
            else
               send_item(OP_CREATE, key_pool[$urandom_range(0, KEY_POOL_N - 1)],
                         BOXID_W'($urandom), $urandom);
         end else if (r < 55) begin
            // send a burst to one queue, then receive from half of it up to two past its end
            n = $urandom_range(1, QDEPTH + 2);
            repeat (n) send_item(OP_SEND, $urandom, 8'(b), $urandom);
            repeat ($urandom_range(n / 2, n + 2)) send_item(OP_RECV, $urandom, 8'(b), $urandom);
         end else if (r < 88) begin
            if ($urandom_range(0, 99) < 55)
               send_item(OP_RECV, $urandom, 8'(b), $urandom);
            else
               send_item(OP_SEND, $urandom, 8'(b), $urandom);
         end else begin
            send_item(OP_W'($urandom_range(0, 3)), $urandom, BOXID_W'($urandom), $urandom);
         end
      end
   endtask

   task automatic test_backpressure;
      set_idling(0, 0);
      hold_seq <= hold_seq + 1;
      random_traffic(40);
   endtask

   task automatic test_random;
      set_idling(0, 0);
      random_traffic(PHASE_ITEMS);
      set_idling(59, 0);
      random_traffic(PHASE_ITEMS);
      set_idling(0, 59);
      random_traffic(PHASE_ITEMS);
      set_idling(36, 36);
      random_traffic(PHASE_ITEMS);
   endtask

   initial begin
      for (int i = 0; i < NBOX; i++) begin
         box_used[i] = 1'b0;
         box_key[i]  = '0;
         rd_ptr[i]   = 0;
         wr_ptr[i]   = 0;
         fill[i]     = 0;
      end
      key_pool[0] = 32'h0000_0000;
      key_pool[1] = 32'h7FFF_FFFF;
      for (int i = 2; i < KEY_POOL_N; i++) key_pool[i] = $urandom & 32'h7FFF_FFFF;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_basic_ops;
      test_queue_full;
      test_table_full;
      test_backpressure;
      test_random;

      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("timeout with %0d items outstanding", pending_rsp.size());
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

/* files.f */
rtl/kmq_pkg.sv
rtl/kmq_box_table.sv
rtl/kmq_msg_store.sv
rtl/keyed_mailbox_queue_manager_unit.sv
tb/sv/tb.sv
